>>> rtl/vbmw_pkg.sv
// Shared types, constants and MD5 round tables for the batch MD5 whitener.
package vbmw_pkg;

    localparam logic [7:0]  MinExtraReset = 8'd4;
    localparam logic [7:0]  MaxExtraReset = 8'd17;
    localparam logic [7:0]  CfgMinExtra   = 8'd0;
    localparam logic [7:0]  CfgMaxExtra   = 8'd1;
    localparam logic [7:0]  MaxSpan       = 8'd200;
    localparam logic [8:0]  BaseBatch     = 9'd16;
    localparam logic [15:0] PoolValueInit = 16'd314;
    localparam logic [15:0] PoolLimitInit = 16'd325;
    localparam logic [7:0]  PadMark       = 8'h80;
    localparam logic [5:0]  LenLoAddr     = 6'd56;
    localparam logic [5:0]  LenHiAddr     = 6'd57;
    localparam logic [5:0]  LastAddr      = 6'd63;
    localparam logic [5:0]  LastRound     = 6'd63;
    localparam logic [3:0]  LastDivStep   = 4'd15;
    localparam logic [3:0]  LastFull      = 4'd15;
    localparam logic [3:0]  LastShort     = 4'd14;

    typedef struct packed {
        logic       byte_we;
        logic       byte_from_in;
        logic [5:0] pad_ptr;
        logic       pad_first;
        logic       pad_final;
        logic       count_inc;
        logic       count_clr;
        logic       div_start;
        logic       div_step;
        logic       tgt_direct;
        logic       tgt_div;
        logic       abcd_init;
        logic       rnd_a;
        logic       rnd_b;
        logic [5:0] round;
        logic       fold;
        logic       chain_init;
        logic       refill;
        logic [3:0] out_idx;
    } cmd_t;

    typedef struct packed {
        logic       count_zero;
        logic       block_full;
        logic       batch_done;
        logic       span_one;
        logic       pad_two;
        logic       refill_need;
        logic [5:0] pad_start;
    } sts_t;

    function automatic logic [31:0] chain_iv(input logic [1:0] i);
        case (i)
            2'd0:    chain_iv = 32'h67452301;
            2'd1:    chain_iv = 32'hefcdab89;
            2'd2:    chain_iv = 32'h98badcfe;
            default: chain_iv = 32'h10325476;
        endcase
    endfunction

    function automatic logic [4:0] round_shift(input logic [5:0] r);
        logic [4:0] s;
        begin
            case ({r[5:4], r[1:0]})
                4'h0: s = 5'd7;  4'h1: s = 5'd12; 4'h2: s = 5'd17; 4'h3: s = 5'd22;
                4'h4: s = 5'd5;  4'h5: s = 5'd9;  4'h6: s = 5'd14; 4'h7: s = 5'd20;
                4'h8: s = 5'd4;  4'h9: s = 5'd11; 4'ha: s = 5'd16; 4'hb: s = 5'd23;
                4'hc: s = 5'd6;  4'hd: s = 5'd10; 4'he: s = 5'd15;
                default: s = 5'd21;
            endcase
            round_shift = s;
        end
    endfunction

    function automatic logic [3:0] msg_index(input logic [5:0] r);
        logic [3:0] x;
        begin
            x = r[3:0];
            case (r[5:4])
                2'd0:    msg_index = x;
                2'd1:    msg_index = 4'((x << 2) + x + 4'd1);
                2'd2:    msg_index = 4'((x << 1) + x + 4'd5);
                default: msg_index = 4'((x << 3) - x);
            endcase
        end
    endfunction

    function automatic logic [31:0] round_const(input logic [5:0] r);
        case (r)
            6'd0:  round_const = 32'hd76aa478; 6'd1:  round_const = 32'he8c7b756;
            6'd2:  round_const = 32'h242070db; 6'd3:  round_const = 32'hc1bdceee;
            6'd4:  round_const = 32'hf57c0faf; 6'd5:  round_const = 32'h4787c62a;
            6'd6:  round_const = 32'ha8304613; 6'd7:  round_const = 32'hfd469501;
            6'd8:  round_const = 32'h698098d8; 6'd9:  round_const = 32'h8b44f7af;
            6'd10: round_const = 32'hffff5bb1; 6'd11: round_const = 32'h895cd7be;
            6'd12: round_const = 32'h6b901122; 6'd13: round_const = 32'hfd987193;
            6'd14: round_const = 32'ha679438e; 6'd15: round_const = 32'h49b40821;
            6'd16: round_const = 32'hf61e2562; 6'd17: round_const = 32'hc040b340;
            6'd18: round_const = 32'h265e5a51; 6'd19: round_const = 32'he9b6c7aa;
            6'd20: round_const = 32'hd62f105d; 6'd21: round_const = 32'h02441453;
            6'd22: round_const = 32'hd8a1e681; 6'd23: round_const = 32'he7d3fbc8;
            6'd24: round_const = 32'h21e1cde6; 6'd25: round_const = 32'hc33707d6;
            6'd26: round_const = 32'hf4d50d87; 6'd27: round_const = 32'h455a14ed;
            6'd28: round_const = 32'ha9e3e905; 6'd29: round_const = 32'hfcefa3f8;
            6'd30: round_const = 32'h676f02d9; 6'd31: round_const = 32'h8d2a4c8a;
            6'd32: round_const = 32'hfffa3942; 6'd33: round_const = 32'h8771f681;
            6'd34: round_const = 32'h6d9d6122; 6'd35: round_const = 32'hfde5380c;
            6'd36: round_const = 32'ha4beea44; 6'd37: round_const = 32'h4bdecfa9;
            6'd38: round_const = 32'hf6bb4b60; 6'd39: round_const = 32'hbebfbc70;
            6'd40: round_const = 32'h289b7ec6; 6'd41: round_const = 32'heaa127fa;
            6'd42: round_const = 32'hd4ef3085; 6'd43: round_const = 32'h04881d05;
            6'd44: round_const = 32'hd9d4d039; 6'd45: round_const = 32'he6db99e5;
            6'd46: round_const = 32'h1fa27cf8; 6'd47: round_const = 32'hc4ac5665;
            6'd48: round_const = 32'hf4292244; 6'd49: round_const = 32'h432aff97;
            6'd50: round_const = 32'hab9423a7; 6'd51: round_const = 32'hfc93a039;
            6'd52: round_const = 32'h655b59c3; 6'd53: round_const = 32'h8f0ccc92;
            6'd54: round_const = 32'hffeff47d; 6'd55: round_const = 32'h85845dd1;
            6'd56: round_const = 32'h6fa87e4f; 6'd57: round_const = 32'hfe2ce6e0;
            6'd58: round_const = 32'ha3014314; 6'd59: round_const = 32'h4e0811a1;
            6'd60: round_const = 32'hf7537e82; 6'd61: round_const = 32'hbd3af235;
            6'd62: round_const = 32'h2ad7d2bb;
            default: round_const = 32'heb86d391;
        endcase
    endfunction

endpackage

>>> rtl/variable_batch_md5_whitener.sv
// Top level of the variable batch MD5 whitener.
//
//  channel  dir  handshake            payload
//  s_       in   s_tvalid/s_tready    s_tdata = in_byte
//  m_       out  m_tvalid/m_tready    m_tdata = out_byte, m_tlast = batch_last
//  cfg_     in   cfg_valid/cfg_ready  cfg_index, cfg_data (min_extra, max_extra)
//
//  A plain byte passes through S_IDLE and S_FULL; the first byte of a batch
//  also runs the bit-serial pool division when the span exceeds one.
//  Each 64-byte block goes through the MD5 round unit, S_RA then S_RB per round;
//  padding writes one byte per cycle, then 15 or 16 digest bytes follow.
//  Reset is synchronous; no item is taken while the digest is being sent,
//  and m_tready low holds the current digest byte.
module variable_batch_md5_whitener
    import vbmw_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // in_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte
    output logic       m_tlast,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_index,
    input  logic [7:0] cfg_data
);

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    vbmw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tlast  (m_tlast),
        .sts      (sts),
        .cmd      (cmd)
    );

    vbmw_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .in_byte  (s_tdata),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_idx  (cfg_index),
        .cfg_val  (cfg_data),
        .out_byte (m_tdata)
    );

    a_no_intake_during_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input ready while digest pending");

    a_busy_after_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready && !m_tvalid)
        else $error("no processing after item");

    a_last_ends_digest: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> !m_tvalid)
        else $error("digest continues after last byte");

endmodule

>>> rtl/vbmw_dp.sv
// Datapath: block memory, MD5 round unit, chaining words, pool divider and counters.
module vbmw_dp
    import vbmw_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  cmd_t        cmd,
    output sts_t        sts,
    input  logic [7:0]  in_byte,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_idx,
    input  logic [7:0]  cfg_val,
    output logic [7:0]  out_byte
);

    logic [7:0]  min_reg, max_reg;
    logic [8:0]  count_reg, target_reg;
    logic [15:0] pool_value_reg, pool_limit_reg;
    logic [15:0] qv_reg, ql_reg;
    logic [7:0]  rv_reg, rl_reg;
    logic [31:0] chain_reg [4];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, tmp_reg, rd_reg;
    logic [31:0] mem [16];

    logic [7:0]  diff, span;
    logic [8:0]  tv, tl;
    logic        bv, bl;
    logic [5:0]  waddr;
    logic [7:0]  wdata, pad_byte;
    logic [31:0] f, rot_in;
    logic [63:0] rot_dbl;
    logic [31:0] out_word;

    always_comb begin
        diff = (max_reg > min_reg) ? 8'(max_reg - min_reg) : 8'd0;
        if (diff > MaxSpan) begin
            diff = MaxSpan;
        end
        span = 8'(diff + 8'd1);

        tv = {1'b0, rv_reg} << 1 | 9'(qv_reg[15]);
        tl = {1'b0, rl_reg} << 1 | 9'(ql_reg[15]);
        bv = tv >= {1'b0, span};
        bl = tl >= {1'b0, span};

        pad_byte = 8'd0;
        if (cmd.pad_first && cmd.pad_ptr == count_reg[5:0]) begin
            pad_byte = PadMark;
        end else if (cmd.pad_final && cmd.pad_ptr == LenLoAddr) begin
            pad_byte = {count_reg[4:0], 3'b000};
        end else if (cmd.pad_final && cmd.pad_ptr == LenHiAddr) begin
            pad_byte = {4'd0, count_reg[8:5]};
        end
        waddr = cmd.byte_from_in ? count_reg[5:0] : cmd.pad_ptr;
        wdata = cmd.byte_from_in ? in_byte : pad_byte;

        case (cmd.round[5:4])
            2'd0:    f = (b_reg & c_reg) | (~b_reg & d_reg);
            2'd1:    f = (d_reg & b_reg) | (~d_reg & c_reg);
            2'd2:    f = b_reg ^ c_reg ^ d_reg;
            default: f = c_reg ^ (b_reg | ~d_reg);
        endcase
        rot_in  = tmp_reg + rd_reg;
        rot_dbl = {rot_in, rot_in} << round_shift(cmd.round);

        out_word = chain_reg[cmd.out_idx[3:2]];
        out_byte = out_word[{cmd.out_idx[1:0], 3'b000} +: 8];

        sts.count_zero  = count_reg == 9'd0;
        sts.block_full  = count_reg[5:0] == 6'd0;
        sts.batch_done  = count_reg >= target_reg;
        sts.span_one    = span == 8'd1;
        sts.pad_two     = count_reg[5:0] >= LenLoAddr;
        sts.refill_need = pool_limit_reg <= {8'd0, span};
        sts.pad_start   = count_reg[5:0];
    end

    always_ff @(posedge aclk) begin
        if (cmd.byte_we) begin
            mem[waddr[5:2]][{waddr[1:0], 3'b000} +: 8] <= wdata;
        end
        rd_reg <= mem[msg_index(cmd.round)];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg        <= MinExtraReset;
            max_reg        <= MaxExtraReset;
            count_reg      <= 9'd0;
            target_reg     <= BaseBatch;
            pool_value_reg <= PoolValueInit;
            pool_limit_reg <= PoolLimitInit;
            for (int i = 0; i < 4; i++) begin
                chain_reg[i] <= chain_iv(2'(i));
            end
        end else begin
            if (cfg_we && cfg_idx == CfgMinExtra) begin
                min_reg <= cfg_val;
            end
            if (cfg_we && cfg_idx == CfgMaxExtra) begin
                max_reg <= cfg_val;
            end
            if (cmd.count_inc) begin
                count_reg <= 9'(count_reg + 9'd1);
            end else if (cmd.count_clr) begin
                count_reg <= 9'd0;
            end
            if (cmd.tgt_direct) begin
                target_reg <= 9'(BaseBatch + {1'b0, min_reg});
            end else if (cmd.tgt_div) begin
                target_reg     <= 9'(BaseBatch + {1'b0, min_reg} + {1'b0, rv_reg});
                pool_value_reg <= qv_reg;
                pool_limit_reg <= ql_reg;
            end else if (cmd.refill && sts.refill_need) begin
                pool_limit_reg <= {8'(pool_limit_reg[7:0] + 8'd1), 8'd0};
                pool_value_reg <= {pool_value_reg[7:0], chain_reg[3][31:24]};
            end
            if (cmd.fold) begin
                chain_reg[0] <= chain_reg[0] + a_reg;
                chain_reg[1] <= chain_reg[1] + b_reg;
                chain_reg[2] <= chain_reg[2] + c_reg;
                chain_reg[3] <= chain_reg[3] + d_reg;
            end else if (cmd.chain_init) begin
                for (int i = 0; i < 4; i++) begin
                    chain_reg[i] <= chain_iv(2'(i));
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            qv_reg <= pool_value_reg;
            ql_reg <= pool_limit_reg;
            rv_reg <= 8'd0;
            rl_reg <= 8'd0;
        end else if (cmd.div_step) begin
            qv_reg <= {qv_reg[14:0], bv};
            ql_reg <= {ql_reg[14:0], bl};
            rv_reg <= bv ? 8'(tv - {1'b0, span}) : tv[7:0];
            rl_reg <= bl ? 8'(tl - {1'b0, span}) : tl[7:0];
        end
        if (cmd.abcd_init) begin
            a_reg <= chain_reg[0];
            b_reg <= chain_reg[1];
            c_reg <= chain_reg[2];
            d_reg <= chain_reg[3];
        end else if (cmd.rnd_a) begin
            tmp_reg <= a_reg + f + round_const(cmd.round);
        end else if (cmd.rnd_b) begin
            a_reg <= d_reg;
            d_reg <= c_reg;
            c_reg <= b_reg;
            b_reg <= b_reg + rot_dbl[63:32];
        end
    end

endmodule

>>> rtl/vbmw_ctrl.sv
// Controller: sequences byte intake, pool draw, compression, padding and digest output.
module vbmw_ctrl
    import vbmw_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    output logic m_tvalid,
    input  logic m_tready,
    output logic m_tlast,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DIV    = 4'd1;
    localparam logic [3:0] S_DLOAD  = 4'd2;
    localparam logic [3:0] S_FULL   = 4'd3;
    localparam logic [3:0] S_CHECK  = 4'd4;
    localparam logic [3:0] S_PAD    = 4'd5;
    localparam logic [3:0] S_RA     = 4'd6;
    localparam logic [3:0] S_RB     = 4'd7;
    localparam logic [3:0] S_FOLD   = 4'd8;
    localparam logic [3:0] S_REFILL = 4'd9;
    localparam logic [3:0] S_OUT    = 4'd10;

    logic [3:0] state_reg, state_next;
    logic [5:0] round_reg, round_next, ptr_reg, ptr_next;
    logic       first_reg, first_next, mode_reg, mode_next;
    logic [3:0] step_reg, step_next, oidx_reg, oidx_next, olast_reg, olast_next;
    logic       pad_final;

    always_comb begin
        pad_final  = !first_reg || !sts.pad_two;
        state_next = state_reg;
        round_next = round_reg;
        ptr_next   = ptr_reg;
        first_next = first_reg;
        mode_next  = mode_reg;
        step_next  = step_reg;
        oidx_next  = oidx_reg;
        olast_next = olast_reg;
        cmd            = '0;
        cmd.round      = round_reg;
        cmd.pad_ptr    = ptr_reg;
        cmd.pad_first  = first_reg;
        cmd.pad_final  = pad_final;
        cmd.out_idx    = oidx_reg;
        s_tready = state_reg == S_IDLE;
        m_tvalid = state_reg == S_OUT;
        m_tlast  = oidx_reg == olast_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.byte_we      = 1'b1;
                    cmd.byte_from_in = 1'b1;
                    cmd.count_inc    = 1'b1;
                    state_next       = S_FULL;
                    if (sts.count_zero && sts.span_one) begin
                        cmd.tgt_direct = 1'b1;
                    end else if (sts.count_zero) begin
                        cmd.div_start = 1'b1;
                        step_next     = 4'd0;
                        state_next    = S_DIV;
                    end
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                step_next    = 4'(step_reg + 4'd1);
                if (step_reg == LastDivStep) begin
                    state_next = S_DLOAD;
                end
            end
            S_DLOAD: begin
                cmd.tgt_div = 1'b1;
                state_next  = S_FULL;
            end
            S_FULL: begin
                if (sts.block_full) begin
                    cmd.abcd_init = 1'b1;
                    mode_next     = 1'b0;
                    round_next    = 6'd0;
                    state_next    = S_RA;
                end else if (sts.batch_done) begin
                    ptr_next   = sts.pad_start;
                    first_next = 1'b1;
                    state_next = S_PAD;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_CHECK: begin
                if (sts.batch_done) begin
                    ptr_next   = sts.pad_start;
                    first_next = 1'b1;
                    state_next = S_PAD;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_PAD: begin
                cmd.byte_we = 1'b1;
                ptr_next    = 6'(ptr_reg + 6'd1);
                if (ptr_reg == LastAddr) begin
                    cmd.abcd_init = 1'b1;
                    mode_next     = 1'b1;
                    round_next    = 6'd0;
                    state_next    = S_RA;
                end
            end
            S_RA: begin
                cmd.rnd_a  = 1'b1;
                state_next = S_RB;
            end
            S_RB: begin
                cmd.rnd_b  = 1'b1;
                round_next = 6'(round_reg + 6'd1);
                state_next = (round_reg == LastRound) ? S_FOLD : S_RA;
            end
            S_FOLD: begin
                cmd.fold = 1'b1;
                if (!mode_reg) begin
                    state_next = S_CHECK;
                end else if (pad_final) begin
                    state_next = S_REFILL;
                end else begin
                    first_next = 1'b0;
                    ptr_next   = 6'd0;
                    state_next = S_PAD;
                end
            end
            S_REFILL: begin
                cmd.refill    = 1'b1;
                cmd.count_clr = 1'b1;
                olast_next    = sts.refill_need ? LastShort : LastFull;
                oidx_next     = 4'd0;
                state_next    = S_OUT;
            end
            S_OUT: begin
                if (m_tready) begin
                    if (oidx_reg == olast_reg) begin
                        cmd.chain_init = 1'b1;
                        state_next     = S_IDLE;
                    end else begin
                        oidx_next = 4'(oidx_reg + 4'd1);
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            round_reg <= 6'd0;
            ptr_reg   <= 6'd0;
            first_reg <= 1'b0;
            mode_reg  <= 1'b0;
            step_reg  <= 4'd0;
            oidx_reg  <= 4'd0;
            olast_reg <= LastFull;
        end else begin
            state_reg <= state_next;
            round_reg <= round_next;
            ptr_reg   <= ptr_next;
            first_reg <= first_next;
            mode_reg  <= mode_next;
            step_reg  <= step_next;
            oidx_reg  <= oidx_next;
            olast_reg <= olast_next;
        end
    end

endmodule
